>>> rtl/lru_k_frame_replacer_core_macros.svh
// Assertion macros shared by the checker of the LRU-K frame replacer.
`ifndef LRU_K_FRAME_REPLACER_CORE_MACROS_SVH
`define LRU_K_FRAME_REPLACER_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LKFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkfr checker: same-cycle property failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define LKFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkfr checker: next-cycle property failed");

`endif

>>> rtl/lkfr_pkg.sv
// Shared constants, codes and types of the LRU-K frame replacer.
package lkfr_pkg;

   localparam int FRAMES      = 64;
   localparam int FRAME_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int COUNT_W     = $clog2(FRAMES + 1);
   localparam int STAMP_W     = 48;
   localparam int TALLY_W     = 4;
   localparam int TALLY_MAX   = 15;
   localparam int DEPTH_RESET = 2;
   localparam int ENTRY_W     = TALLY_W + STAMP_W;

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_SET    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_EVICT  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_REFUSED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACC_WR,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/lkfr_frame_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module lkfr_frame_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lru_k_frame_replacer_core.sv
// Record, set and remove go from execute (plus an access write when record hits a present frame)
// to the finishing state, which loads the output register. Evict walks every frame's stamp through
// one shared comparator. The block takes one item at a time: a new input transfer is accepted
// only in idle, after the previous result has been loaded. The scan reads one frame per cycle.
// Reset is synchronous and active high; it clears all frame flags, the counter and the clock.
// The stamp memory needs no clearing: an entry's contents are only used while its frame is present.
module lru_k_frame_replacer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [5:0] frame_number, [6] evictable_flag, [7] zero
   input  logic [1:0]  req_tuser,  // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [5:0] victim_frame, [12:6] evictable_total, [15:13] zero
   output logic [1:0]  rsp_tuser,  // [1:0] status
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata   // [3:0] history_depth
);

   localparam int FW = lkfr_pkg::FRAME_W;
   localparam int SW = lkfr_pkg::STAMP_W;
   localparam int TW = lkfr_pkg::TALLY_W;
   localparam int CW = lkfr_pkg::COUNT_W;
   localparam int EW = lkfr_pkg::ENTRY_W;
   localparam int NF = lkfr_pkg::FRAMES;

   // Sequencer state.
   lkfr_pkg::state_type state_ff, state_in;

   // Latched request.
   lkfr_pkg::action_type act_ff;
   logic [5:0]           fnum_ff;
   logic                 flag_ff;

   // Per-frame flags live in flip-flops so that reset clears them at once.
   logic [NF-1:0] present_ff;
   logic [NF-1:0] cache_ff;
   logic [NF-1:0] evict_ff;

   logic [CW-1:0] count_ff;
   logic [TW-1:0] depth_ff;
   logic [SW-1:0] stamp_clock_ff;

   // Result waiting for the output register, and the output register itself.
   lkfr_pkg::status_type res_status_ff;
   logic [FW-1:0]        res_victim_ff;
   logic                 rsp_valid_ff;
   lkfr_pkg::status_type rsp_status_ff;
   logic [5:0]           rsp_victim_ff;
   logic [6:0]           rsp_total_ff;

   // Evict scan: an address counter feeds the memory, and the returning stamp is
   // compared against the running best of its own group in the following cycle.
   logic [FW-1:0] scan_addr_ff;
   logic          scan_issue_ff;
   logic          cmp_valid_ff;
   logic [FW-1:0] cmp_idx_ff;
   logic [1:0]    found_ff;
   logic [SW-1:0] best_ff [2];
   logic [FW-1:0] pick_ff [2];

   // Stamp memory ports.
   logic          rd_en;
   logic [FW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          wr_en;
   logic [FW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // Decoded request.
   logic [FW-1:0] frame_idx;
   logic          in_range;
   logic          cur_present;
   logic          cur_evict;
   logic          cur_cache;
   logic          accept;

   // Access update path.
   logic [TW-1:0] rd_tally;
   logic [SW-1:0] rd_stamp;
   logic [TW-1:0] tally_inc;
   logic          move_up;

   // Shared comparator path.
   logic          cmp_grp;
   logic          cmp_take;
   logic          scan_done;
   logic          victim_hit;
   logic [FW-1:0] victim_idx;

   assign accept      = req_tvalid && req_tready;
   assign frame_idx   = FW'(fnum_ff);
   assign in_range    = (32'(fnum_ff) < 32'(NF));
   assign cur_present = present_ff[frame_idx];
   assign cur_evict   = evict_ff[frame_idx];
   assign cur_cache   = cache_ff[frame_idx];

   assign rd_tally  = rd_data[SW +: TW];
   assign rd_stamp  = rd_data[SW-1:0];
   assign tally_inc = (rd_tally == TW'(lkfr_pkg::TALLY_MAX)) ? rd_tally : rd_tally + TW'(1);
   assign move_up   = (tally_inc >= depth_ff);

   // One magnitude compare serves both groups: the candidate's group selects
   // which running best it is measured against. A strict compare keeps the lower
   // frame number on equal stamps.
   assign cmp_grp    = cache_ff[cmp_idx_ff];
   assign cmp_take   = cmp_valid_ff && present_ff[cmp_idx_ff] && evict_ff[cmp_idx_ff] &&
                       (!found_ff[cmp_grp] || (rd_stamp < best_ff[cmp_grp]));
   assign scan_done  = !scan_issue_ff && !cmp_valid_ff;
   assign victim_hit = found_ff[0] || found_ff[1];
   assign victim_idx = found_ff[0] ? pick_ff[0] : pick_ff[1];

   lkfr_frame_ram #(
      .WIDTH (EW),
      .DEPTH (NF)
   ) u_frame_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkfr_pkg::ST_IDLE: begin
            if (accept) state_in = lkfr_pkg::ST_EXEC;
         end
         lkfr_pkg::ST_EXEC: begin
            if (act_ff == lkfr_pkg::ACT_EVICT) begin
               state_in = lkfr_pkg::ST_SCAN;
            end else if (in_range && (act_ff == lkfr_pkg::ACT_RECORD) && cur_present) begin
               state_in = lkfr_pkg::ST_ACC_WR;
            end else begin
               state_in = lkfr_pkg::ST_FINISH;
            end
         end
         lkfr_pkg::ST_ACC_WR: begin
            state_in = lkfr_pkg::ST_FINISH;
         end
         lkfr_pkg::ST_SCAN: begin
            if (scan_done) state_in = lkfr_pkg::ST_FINISH;
         end
         lkfr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = lkfr_pkg::ST_IDLE;
         end
         default: state_in = lkfr_pkg::ST_IDLE;
      endcase
   end

   // Output and memory control logic.
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = frame_idx;
      wr_en      = 1'b0;
      wr_addr    = frame_idx;
      wr_data    = {TW'(1), stamp_clock_ff};
      unique case (state_ff)
         lkfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         lkfr_pkg::ST_EXEC: begin
            // A present frame needs its tally and stamp back; a new one is written fresh.
            rd_en = 1'b1;
            if (in_range && (act_ff == lkfr_pkg::ACT_RECORD) && !cur_present) begin
               wr_en = 1'b1;
            end
         end
         lkfr_pkg::ST_ACC_WR: begin
            wr_en = 1'b1;
            if (cur_cache) begin
               wr_data = {rd_tally, stamp_clock_ff};
            end else if (move_up) begin
               wr_data = {tally_inc, stamp_clock_ff};
            end else begin
               wr_data = {tally_inc, rd_stamp};
            end
         end
         lkfr_pkg::ST_SCAN: begin
            rd_en   = scan_issue_ff;
            rd_addr = scan_addr_ff;
         end
         lkfr_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers and frame flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lkfr_pkg::ST_IDLE;
         present_ff     <= '0;
         cache_ff       <= '0;
         evict_ff       <= '0;
         count_ff       <= '0;
         depth_ff       <= TW'(lkfr_pkg::DEPTH_RESET);
         stamp_clock_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_issue_ff  <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         found_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) depth_ff <= csr_wdata;
         // The finishing state reloads the output register itself.
         if (rsp_valid_ff && rsp_tready && (state_ff != lkfr_pkg::ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            lkfr_pkg::ST_IDLE: begin
            end
            lkfr_pkg::ST_EXEC: begin
               unique case (act_ff)
                  lkfr_pkg::ACT_RECORD: begin
                     if (in_range && !cur_present) begin
                        // First access: the frame enters the history group as evictable.
                        present_ff[frame_idx] <= 1'b1;
                        cache_ff[frame_idx]   <= 1'b0;
                        evict_ff[frame_idx]   <= 1'b1;
                        count_ff              <= count_ff + CW'(1);
                        stamp_clock_ff        <= stamp_clock_ff + SW'(1);
                     end
                  end
                  lkfr_pkg::ACT_SET: begin
                     if (in_range && cur_present) begin
                        if (flag_ff && !cur_evict) begin
                           count_ff <= count_ff + CW'(1);
                        end else if (!flag_ff && cur_evict && (count_ff != '0)) begin
                           count_ff <= count_ff - CW'(1);
                        end
                        evict_ff[frame_idx] <= flag_ff;
                     end
                  end
                  lkfr_pkg::ACT_REMOVE: begin
                     if (in_range && cur_present && cur_evict) begin
                        present_ff[frame_idx] <= 1'b0;
                        cache_ff[frame_idx]   <= 1'b0;
                        evict_ff[frame_idx]   <= 1'b0;
                        if (count_ff != '0) count_ff <= count_ff - CW'(1);
                     end
                  end
                  lkfr_pkg::ACT_EVICT: begin
                     scan_issue_ff <= 1'b1;
                     cmp_valid_ff  <= 1'b0;
                     found_ff      <= '0;
                  end
                  default: begin
                  end
               endcase
            end
            lkfr_pkg::ST_ACC_WR: begin
               stamp_clock_ff <= stamp_clock_ff + SW'(1);
               if (!cur_cache && move_up) cache_ff[frame_idx] <= 1'b1;
            end
            lkfr_pkg::ST_SCAN: begin
               cmp_valid_ff <= scan_issue_ff;
               if (scan_issue_ff && (scan_addr_ff == FW'(NF - 1))) scan_issue_ff <= 1'b0;
               if (cmp_take) found_ff[cmp_grp] <= 1'b1;
               if (scan_done && victim_hit) begin
                  // History group wins over cache group; the chosen frame is dropped.
                  present_ff[victim_idx] <= 1'b0;
                  cache_ff[victim_idx]   <= 1'b0;
                  evict_ff[victim_idx]   <= 1'b0;
                  if (count_ff != '0) count_ff <= count_ff - CW'(1);
               end
            end
            lkfr_pkg::ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         lkfr_pkg::ST_IDLE: begin
            if (accept) begin
               act_ff  <= lkfr_pkg::action_type'(req_tuser);
               fnum_ff <= req_tdata[5:0];
               flag_ff <= req_tdata[6];
            end
         end
         lkfr_pkg::ST_EXEC: begin
            res_victim_ff <= '0;
            scan_addr_ff  <= '0;
            if (act_ff == lkfr_pkg::ACT_EVICT) begin
               res_status_ff <= lkfr_pkg::STAT_OK;
            end else if (!in_range) begin
               res_status_ff <= lkfr_pkg::STAT_RANGE;
            end else if ((act_ff == lkfr_pkg::ACT_REMOVE) && cur_present && !cur_evict) begin
               res_status_ff <= lkfr_pkg::STAT_REFUSED;
            end else begin
               res_status_ff <= lkfr_pkg::STAT_OK;
            end
         end
         lkfr_pkg::ST_ACC_WR: begin
         end
         lkfr_pkg::ST_SCAN: begin
            cmp_idx_ff <= scan_addr_ff;
            if (scan_issue_ff) scan_addr_ff <= scan_addr_ff + FW'(1);
            if (cmp_take) begin
               best_ff[cmp_grp] <= rd_stamp;
               pick_ff[cmp_grp] <= cmp_idx_ff;
            end
            if (scan_done) begin
               if (victim_hit) begin
                  res_status_ff <= lkfr_pkg::STAT_OK;
                  res_victim_ff <= victim_idx;
               end else begin
                  res_status_ff <= lkfr_pkg::STAT_EMPTY;
                  res_victim_ff <= '0;
               end
            end
         end
         lkfr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_status_ff <= res_status_ff;
               rsp_victim_ff <= 6'(res_victim_ff);
               rsp_total_ff  <= 7'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_victim_ff};

endmodule

>>> rtl/lkfr_checker.sv
// Port-level checker of the LRU-K frame replacer, bound to the top level.
`include "lru_k_frame_replacer_core_macros.svh"

module lkfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic        req_xfer;
   logic        rsp_stall;
   logic [17:0] rsp_payload;
   logic        rsp_not_ok;
   logic [6:0]  rsp_total;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_payload = {rsp_tuser, rsp_tdata};
   assign rsp_not_ok  = rsp_tvalid && (rsp_tuser != lkfr_pkg::STAT_OK);
   assign rsp_total   = rsp_tdata[12:6];

   // A stalled result holds its payload.
   `LKFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_payload))

   // The block works on one item at a time, so it is busy right after an input transfer.
   `LKFR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_tready)

   // Only a successful evict names a victim.
   `LKFR_ASSERT_SAME(a_victim_zero, clock, reset, rsp_not_ok, rsp_tdata[5:0] == 6'd0)

   // The evictable count never exceeds the number of frames.
   `LKFR_ASSERT_SAME(a_total_bound, clock, reset, rsp_tvalid, 32'(rsp_total) <= lkfr_pkg::FRAMES)

endmodule

bind lru_k_frame_replacer_core lkfr_checker u_lkfr_checker (.*);
